// ===== sv/scct_pkg.sv =====
package scct_pkg;

  localparam int unsigned NumCh = 10;

  // Tristimulus sums: 16-bit counts times 20-bit signed coefficients, ten terms.
  localparam int unsigned TriW = 50;

  // Stage 4 x, y quotients are 42 bits, kept in 43; the subtraction widens to 44.
  localparam int unsigned QW = 43;
  localparam int unsigned NW = 24;

  // Each division retires one quotient bit per pipeline stage.
  localparam int unsigned DivW = 64;

  typedef logic signed [19:0] coef_t;
  typedef coef_t coef_row_t [NumCh];

  localparam coef_row_t CoefX = '{
    20'sd26093, 20'sd84895, 20'sd24219, 20'sd7145, 20'sd47148,
    20'sd116772, 20'sd72162, -20'sd2616, -20'sd18086, -20'sd1538
  };
  localparam coef_row_t CoefY = '{
    20'sd915, 20'sd10976, 20'sd15426, 20'sd93553, 20'sd123647,
    20'sd74842, 20'sd30472, -20'sd1771, -20'sd16035, -20'sd1306
  };
  localparam coef_row_t CoefZ = '{
    20'sd127802, 20'sd423028, 20'sd182197, 20'sd12125, 20'sd10043,
    20'sd6251, 20'sd6923, 20'sd5810, -20'sd40069, -20'sd615
  };

  localparam logic signed [QW-1:0] XOfs = QW'(21758);
  localparam logic signed [QW-1:0] YOfs = QW'(12177);

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StZeroS  = 2'd1,
    StZeroD  = 2'd2,
    StClamp  = 2'd3
  } status_e;

endpackage

// ===== sv/scct_if.sv =====
interface scct_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] band1;
  logic [15:0] band2;
  logic [15:0] band3;
  logic [15:0] band4;
  logic [15:0] band5;
  logic [15:0] band6;
  logic [15:0] band7;
  logic [15:0] band8;
  logic [15:0] clear_count;
  logic [15:0] infrared_count;

  modport source (output valid, band1, band2, band3, band4, band5, band6, band7, band8,
                  clear_count, infrared_count, input ready);
  modport sink (input valid, band1, band2, band3, band4, band5, band6, band7, band8,
                clear_count, infrared_count, output ready);
endinterface

interface scct_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] colour_temp;
  logic [1:0]  status;

  modport source (output valid, colour_temp, status, input ready);
  modport sink (input valid, colour_temp, status, output ready);
endinterface

// ===== sv/scct_sdiv.sv =====
// Pipelined signed divider, truncating toward zero; one quotient bit per stage.
// Works on magnitudes: DW-bit numerator magnitude, DW-bit denominator magnitude.
module scct_sdiv #(
  parameter int unsigned DW = 64,
  parameter int unsigned TW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic          neg_i,
  input  logic [TW-1:0] tag_i,
  output logic [DW-1:0] quo_o,
  output logic          neg_o,
  output logic [TW-1:0] tag_o
);

  logic [DW-1:0] rem_q [DW+1];
  logic [DW-1:0] num_q [DW+1];
  logic [DW-1:0] den_q [DW+1];
  logic          neg_q [DW+1];
  logic [TW-1:0] tag_q [DW+1];

  always_comb begin
    rem_q[0] = '0;
    num_q[0] = num_i;
    den_q[0] = den_i;
    neg_q[0] = neg_i;
    tag_q[0] = tag_i;
  end

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [DW:0]   trial;
    logic [DW-1:0] rem_d;
    logic [DW-1:0] num_d;
    always_comb begin
      trial = {rem_q[k], num_q[k][DW-1]} - {1'b0, den_q[k]};
      if (!trial[DW]) begin
        rem_d = trial[DW-1:0];
        num_d = {num_q[k][DW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[k][DW-2:0], num_q[k][DW-1]};
        num_d = {num_q[k][DW-2:0], 1'b0};
      end
    end
    logic [DW-1:0] r_q, n_q, d_q;
    logic          g_q;
    logic [TW-1:0] t_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        t_q <= '0;
      end else if (en_i) begin
        t_q <= tag_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q <= rem_d;
        n_q <= num_d;
        d_q <= den_q[k];
        g_q <= neg_q[k];
      end
    end
    always_comb begin
      rem_q[k+1] = r_q;
      num_q[k+1] = n_q;
      den_q[k+1] = d_q;
      neg_q[k+1] = g_q;
      tag_q[k+1] = t_q;
    end
  end

  assign quo_o = num_q[DW];
  assign neg_o = neg_q[DW];
  assign tag_o = tag_q[DW];

endmodule

// ===== sv/spectral_cct_mccamy_top.sv =====
// The pipeline has 142 register stages (3 + 66 + 2 + 64 + 7); the
// bit-per-stage dividers set the depth.
// It accepts one transaction per cycle while the output is not stalled.
// The whole pipeline advances only when the output register can take data,
// so a stall holds every stage in place.
// Reset clears all valid bits and divider tags; other payload is not reset.
module spectral_cct_mccamy_top #(
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  scct_in_if.sink    in_i,
  scct_out_if.source out_o
);
  import scct_pkg::*;

  // Counts are 16 bits wide; only the low CHANNEL_BITS of each are used.
  localparam logic [15:0] CntMask = (CHANNEL_BITS >= 16) ? 16'hFFFF
                                    : 16'((32'd1 << CHANNEL_BITS) - 32'd1);

  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Valid bits for the front stages.
  logic [2:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[1:0], in_i.valid};
    end
  end

  // Stage 1: per-channel products.
  logic [15:0] cnt [NumCh];
  always_comb begin
    cnt[0] = in_i.band1 & CntMask;
    cnt[1] = in_i.band2 & CntMask;
    cnt[2] = in_i.band3 & CntMask;
    cnt[3] = in_i.band4 & CntMask;
    cnt[4] = in_i.band5 & CntMask;
    cnt[5] = in_i.band6 & CntMask;
    cnt[6] = in_i.band7 & CntMask;
    cnt[7] = in_i.band8 & CntMask;
    cnt[8] = in_i.clear_count & CntMask;
    cnt[9] = in_i.infrared_count & CntMask;
  end

  logic signed [TriW-1:0] prx_q [NumCh];
  logic signed [TriW-1:0] pry_q [NumCh];
  logic signed [TriW-1:0] prz_q [NumCh];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NumCh; c++) begin
        prx_q[c] <= TriW'(CoefX[c]) * TriW'($signed({1'b0, cnt[c]}));
        pry_q[c] <= TriW'(CoefY[c]) * TriW'($signed({1'b0, cnt[c]}));
        prz_q[c] <= TriW'(CoefZ[c]) * TriW'($signed({1'b0, cnt[c]}));
      end
    end
  end

  // Stage 2: tristimulus sums.
  logic signed [TriW-1:0] tx_q, ty_q, tz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q <= prx_q[0] + prx_q[1] + prx_q[2] + prx_q[3] + prx_q[4]
            + prx_q[5] + prx_q[6] + prx_q[7] + prx_q[8] + prx_q[9];
      ty_q <= pry_q[0] + pry_q[1] + pry_q[2] + pry_q[3] + pry_q[4]
            + pry_q[5] + pry_q[6] + pry_q[7] + pry_q[8] + pry_q[9];
      tz_q <= prz_q[0] + prz_q[1] + prz_q[2] + prz_q[3] + prz_q[4]
            + prz_q[5] + prz_q[6] + prz_q[7] + prz_q[8] + prz_q[9];
    end
  end

  // Stage 3: sum S and magnitudes for the x, y divisions.
  localparam int unsigned XyNW = TriW + 16;
  logic signed [TriW+1:0] s_w;
  assign s_w = (TriW+2)'(tx_q) + (TriW+2)'(ty_q) + (TriW+2)'(tz_q);
  logic [XyNW-1:0] xnum_q, ynum_q;
  logic [TriW+1:0] sabs_q;
  logic            xneg_q, yneg_q, szero_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      xnum_q  <= tx_q[TriW-1] ? XyNW'(-{{16{tx_q[TriW-1]}}, tx_q, 16'd0} >>> 0)
                              : XyNW'({tx_q, 16'd0});
      ynum_q  <= ty_q[TriW-1] ? XyNW'(-{{16{ty_q[TriW-1]}}, ty_q, 16'd0} >>> 0)
                              : XyNW'({ty_q, 16'd0});
      sabs_q  <= s_w[TriW+1] ? -s_w : s_w;
      xneg_q  <= tx_q[TriW-1] ^ s_w[TriW+1];
      yneg_q  <= ty_q[TriW-1] ^ s_w[TriW+1];
      szero_q <= s_w == '0;
    end
  end

  // x and y divisions: full-width restoring division on magnitudes, then
  // saturation at 2^40. The y divider's tag carries the valid bit.
  logic [XyNW-1:0] xq, yq;
  logic            xn, yn;
  logic            tg_x;
  logic            tg_y;
  scct_sdiv #(.DW(XyNW), .TW(1)) u_divx (
    .clk_i, .rst_ni, .en_i(en),
    .num_i(xnum_q), .den_i(XyNW'(sabs_q)), .neg_i(xneg_q), .tag_i(szero_q),
    .quo_o(xq), .neg_o(xn), .tag_o(tg_x)
  );
  scct_sdiv #(.DW(XyNW), .TW(1)) u_divy (
    .clk_i, .rst_ni, .en_i(en),
    .num_i(ynum_q), .den_i(XyNW'(sabs_q)), .neg_i(yneg_q), .tag_i(vld_q[2]),
    .quo_o(yq), .neg_o(yn), .tag_o(tg_y)
  );

  // Saturate x and y to 2^40 and register them.
  localparam logic [XyNW-1:0] XyLim = XyNW'(64'd1 << 40);
  logic [XyNW-1:0] xm, ym;
  logic signed [QW-1:0] xs, ys;
  assign xm = (xq > XyLim) ? XyLim : xq;
  assign ym = (yq > XyLim) ? XyLim : yq;
  assign xs = xn ? -QW'(xm) : QW'(xm);
  assign ys = yn ? -QW'(ym) : QW'(ym);

  logic signed [QW-1:0] xs_q, ys_q;
  logic                 szx_q, vxy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      xs_q  <= xs;
      ys_q  <= ys;
      szx_q <= tg_x;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vxy_q <= 1'b0;
    end else if (en) begin
      vxy_q <= tg_y;
    end
  end

  // Form n numerator and d.
  logic signed [QW:0] nn_w, dd_w;
  assign nn_w = (QW+1)'(xs_q) - (QW+1)'(XOfs);
  assign dd_w = (QW+1)'(YOfs) - (QW+1)'(ys_q);

  logic [DivW-1:0] nnum_q, nden_q;
  logic            nneg_q, dzero_q, sz2_q, v3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      nnum_q  <= DivW'(nn_w[QW] ? -nn_w : nn_w) << 16;
      nden_q  <= DivW'(dd_w[QW] ? -dd_w : dd_w);
      nneg_q  <= nn_w[QW] ^ dd_w[QW];
      dzero_q <= dd_w == '0;
      sz2_q   <= szx_q;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= vxy_q;
    end
  end

  logic [DivW-1:0] nq;
  logic            nng;
  logic [1:0]      tg_n;
  scct_sdiv #(.DW(DivW), .TW(2)) u_divn (
    .clk_i, .rst_ni, .en_i(en),
    .num_i(nnum_q), .den_i(nden_q), .neg_i(nneg_q), .tag_i({sz2_q, dzero_q}),
    .quo_o(nq), .neg_o(nng), .tag_o(tg_n)
  );

  logic [DivW-1:0] v4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= '0;
    end else if (en) begin
      v4_q <= {v4_q[DivW-2:0], v3_q};
    end
  end

  // Saturate n to +-2^22.
  localparam logic [DivW-1:0] NLim = DivW'(64'd1 << 22);
  logic [DivW-1:0]       nm;
  logic signed [NW-1:0]  ns;
  assign nm = (nq > NLim) ? NLim : nq;
  assign ns = nng ? -NW'(nm) : NW'(nm);

  // Polynomial stages: register n, n^2, then n^3, then weighted sum.
  logic signed [NW-1:0] p0_n_q;
  logic [1:0]           p0_tg_q;
  logic signed [NW-1:0] p1_n_q;
  logic signed [47:0]   p1_sq_q;
  logic [1:0]           p1_tg_q;
  logic signed [NW-1:0] p2_n_q;
  logic signed [31:0]   p2_n2_q;
  logic [1:0]           p2_tg_q;
  logic signed [NW-1:0] p3_n_q;
  logic signed [31:0]   p3_n2_q;
  logic signed [55:0]   p3_cu_q;
  logic [1:0]           p3_tg_q;
  logic signed [63:0]   p4_a_q, p4_b_q;
  logic [1:0]           p4_tg_q;
  logic signed [63:0]   p5_p_q;
  logic [1:0]           p5_tg_q;
  logic [15:0]          ct_q;
  logic [1:0]           st_q;
  logic                 ov_q;

  // Truncating divide by 2^16 toward zero.
  function automatic logic signed [63:0] tdiv16(input logic signed [63:0] v);
    logic signed [63:0] adj;
    adj = v[63] ? v + 64'sd65535 : v;
    return adj >>> 16;
  endfunction

  logic signed [63:0] sq_t, cu_t, p_t;
  assign sq_t = tdiv16(64'(p1_sq_q));
  assign cu_t = tdiv16(64'(p3_cu_q));
  assign p_t  = tdiv16(p5_p_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_n_q  <= ns;
      p0_tg_q <= tg_n;
      p1_n_q  <= p0_n_q;
      p1_sq_q <= 48'(p0_n_q) * 48'(p0_n_q);
      p1_tg_q <= p0_tg_q;
      p2_n_q  <= p1_n_q;
      p2_n2_q <= 32'(sq_t);
      p2_tg_q <= p1_tg_q;
      p3_n_q  <= p2_n_q;
      p3_n2_q <= p2_n2_q;
      p3_cu_q <= 56'(p2_n2_q) * 56'(p2_n_q);
      p3_tg_q <= p2_tg_q;
      p4_a_q  <= 64'sd437 * cu_t + 64'sd3601 * 64'(p3_n2_q);
      p4_b_q  <= 64'sd6831 * 64'(p3_n_q) + 64'(64'sd5517 <<< 16);
      p4_tg_q <= p3_tg_q;
      p5_p_q  <= p4_a_q + p4_b_q;
      p5_tg_q <= p4_tg_q;
      if (p5_tg_q[1]) begin
        ct_q <= '0;
        st_q <= StZeroS;
      end else if (p5_tg_q[0]) begin
        ct_q <= '0;
        st_q <= StZeroD;
      end else if (p_t < 0) begin
        ct_q <= '0;
        st_q <= StClamp;
      end else if (p_t > 64'sd65535) begin
        ct_q <= 16'hFFFF;
        st_q <= StClamp;
      end else begin
        ct_q <= p_t[15:0];
        st_q <= StOk;
      end
    end
  end

  logic [5:0] v5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      v5_q <= {v5_q[4:0], v4_q[DivW-1]};
      ov_q <= v5_q[5];
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.colour_temp = ct_q;
  assign out_o.status      = st_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.colour_temp)
      && $stable(out_o.status));
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready);
  a_zero_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == StZeroS || out_o.status == StZeroD)
      |-> out_o.colour_temp == '0);
`endif

endmodule
